[src/lca_pkg.sv]
// Shared types, constants and the interval test for the LCA block.
// No dependencies; imported by lca_binary_lifting_top.
package lca_pkg;

  localparam int NODE_W = 10;
  localparam int TIME_W = 12;
  localparam int NODES  = 1 << NODE_W;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [TIME_W-1:0] stamp_t;

  // request codes carried on req_type
  typedef enum logic [1:0] {
    REQ_ENTER = 2'd0,
    REQ_LEAVE = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ENTER_L1,
    S_ENTER_RD,
    S_ENTER_WR,
    S_Q_RB,
    S_Q_RA,
    S_Q_TEST,
    S_L_TIME,
    S_L_CMP,
    S_Q_PAR
  } state_t;

  // x is an ancestor of y when its entry/exit interval contains y's
  function automatic logic covers(stamp_t ent_x, stamp_t ext_x, stamp_t ent_y, stamp_t ext_y);
    covers = (ent_x <= ent_y) && (ext_x >= ext_y);
  endfunction

endpackage

[src/lca_ram.sv]
// Generic single-write, single-read memory with registered read data.
// Depends on nothing; a read at the address being written returns old data.
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/lca_binary_lifting_top.sv]
// Lowest common ancestor by binary lifting (uses lca_pkg, lca_ram). Leave is
// accepted without raising busy; enter keeps busy while it fills the ancestor table.
// Query: the result strobe follows the pair test when one node contains the
// other, else the lifting levels and a parent read; each lifting level does an
// ancestor read, then a time read. Synchronous reset sets the time counter to
// one and returns to idle; memories are not cleared. Results cannot be stalled.
module lca_binary_lifting_top
  import lca_pkg::*;
#(
  parameter int LEVELS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  output logic              done,
  output logic [NODE_W-1:0] lca_node
);

  localparam int LW     = $clog2(LEVELS + 1);
  localparam int ANC_AW = LW + NODE_W;

  typedef logic [LW-1:0] lvl_t;

  state_t state, state_next;
  stamp_t counter;
  node_t  a_reg, b_reg, cur, u, up;
  lvl_t   lvl;
  stamp_t eb, xb;

  logic  accept;
  lvl_t  lvl_inc, lvl_dec;
  logic  cov_ab, cov_ba, cov_up;
  node_t u_next;

  // memory ports
  logic                ent_we, ext_we, par_we, anc_we;
  node_t               wnode, time_raddr, par_raddr;
  stamp_t              ent_rdata, ext_rdata;
  node_t               par_rdata, anc_wdata, anc_rdata;
  logic [ANC_AW-1:0]   anc_waddr, anc_raddr;

  lca_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_entry (
    .clk(clk), .we(ent_we), .waddr(wnode), .wdata(counter),
    .raddr(time_raddr), .rdata(ent_rdata)
  );

  lca_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_exit (
    .clk(clk), .we(ext_we), .waddr(wnode), .wdata(counter),
    .raddr(time_raddr), .rdata(ext_rdata)
  );

  lca_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent (
    .clk(clk), .we(par_we), .waddr(wnode), .wdata(node_b),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  lca_ram #(.WIDTH(NODE_W), .DEPTH((1 << LW) * NODES)) u_anc (
    .clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
    .raddr(anc_raddr), .rdata(anc_rdata)
  );

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign lvl_inc = lvl + lvl_t'(1);
  assign lvl_dec = lvl - lvl_t'(1);

  // ancestor tests: query pair from time reads, lifted node against b
  assign cov_ab = covers(ent_rdata, ext_rdata, eb, xb);
  assign cov_ba = covers(eb, xb, ent_rdata, ext_rdata);
  assign cov_up = covers(ent_rdata, ext_rdata, eb, xb);
  assign u_next = cov_up ? u : up;
  assign wnode  = node_a;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_ENTER) begin
            state_next = S_ENTER_L1;
          end else if (req_type == REQ_QUERY) begin
            state_next = S_Q_RB;
          end
        end
      end
      S_ENTER_L1: state_next = S_ENTER_RD;
      S_ENTER_RD: state_next = S_ENTER_WR;
      S_ENTER_WR: state_next = (lvl_inc == lvl_t'(LEVELS)) ? S_IDLE : S_ENTER_RD;
      S_Q_RB:     state_next = S_Q_RA;
      S_Q_RA:     state_next = S_Q_TEST;
      S_Q_TEST:   state_next = (cov_ab || cov_ba) ? S_IDLE : S_L_TIME;
      S_L_TIME:   state_next = S_L_CMP;
      S_L_CMP:    state_next = (lvl == lvl_t'(0)) ? S_Q_PAR : S_L_TIME;
      S_Q_PAR:    state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory controls per state
  always_comb begin
    ent_we     = 1'b0;
    ext_we     = 1'b0;
    par_we     = 1'b0;
    anc_we     = 1'b0;
    anc_waddr  = {lvl_t'(0), node_a};
    anc_wdata  = node_a;
    anc_raddr  = {lvl, cur};
    time_raddr = b_reg;
    par_raddr  = u_next;
    unique case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_ENTER) begin
          ent_we = 1'b1;
          par_we = 1'b1;
          anc_we = 1'b1;
        end
        if (accept && req_type == REQ_LEAVE) begin
          ext_we = 1'b1;
        end
      end
      S_ENTER_L1: begin
        anc_we    = 1'b1;
        anc_waddr = {lvl_t'(1), a_reg};
        anc_wdata = b_reg;
      end
      S_ENTER_RD: anc_raddr = {lvl, cur};
      S_ENTER_WR: begin
        anc_we    = 1'b1;
        anc_waddr = {lvl_inc, a_reg};
        anc_wdata = anc_rdata;
      end
      S_Q_RB:   time_raddr = b_reg;
      S_Q_RA:   time_raddr = a_reg;
      S_Q_TEST: anc_raddr  = {lvl_t'(LEVELS), a_reg};
      S_L_TIME: time_raddr = anc_rdata;
      S_L_CMP: begin
        anc_raddr = {lvl_dec, u_next};
        par_raddr = u_next;
      end
      S_Q_PAR: ;
      default: ;
    endcase
  end

  // sequencer registers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      counter <= stamp_t'(1);
      done    <= 1'b0;
      lvl     <= lvl_t'(0);
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            a_reg <= node_a;
            b_reg <= node_b;
            if (req_type == REQ_ENTER || req_type == REQ_LEAVE) begin
              counter <= counter + stamp_t'(1);
            end
          end
        end
        S_ENTER_L1: begin
          cur <= b_reg;
          lvl <= lvl_t'(1);
        end
        S_ENTER_WR: begin
          cur <= anc_rdata;
          lvl <= lvl_inc;
        end
        S_Q_RA: begin
          eb <= ent_rdata;
          xb <= ext_rdata;
        end
        S_Q_TEST: begin
          if (cov_ab) begin
            lca_node <= a_reg;
            done     <= 1'b1;
          end else if (cov_ba) begin
            lca_node <= b_reg;
            done     <= 1'b1;
          end else begin
            u   <= a_reg;
            lvl <= lvl_t'(LEVELS);
          end
        end
        S_L_TIME: up <= anc_rdata;
        S_L_CMP: begin
          u   <= u_next;
          lvl <= lvl_dec;
        end
        S_Q_PAR: begin
          lca_node <= par_rdata;
          done     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  // result only follows the pair test or the parent read
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_Q_TEST || $past(state) == S_Q_PAR))
    else $error("result strobe from unexpected state");

  // enter and leave advance the stamp counter by one
  a_stamp: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == REQ_ENTER || req_type == REQ_LEAVE))
      |=> counter == stamp_t'($past(counter) + stamp_t'(1)))
    else $error("time counter did not advance");

  // lifting level stays within the table
  a_lvl: assert property (@(posedge clk) disable iff (rst)
    (state == S_L_TIME || state == S_ENTER_RD) |-> lvl <= lvl_t'(LEVELS))
    else $error("ancestor level out of range");

  // no query in flight while busy is low
  a_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_QUERY) |=> busy)
    else $error("query accepted without going busy");

endmodule
